// File: hdl/daex_pkg.sv
// Shared types and constants for the DNS answer address extractor.
// No dependencies; used by every module in hdl/.
package daex_pkg;

   // Byte queue between the front and back parts
   localparam int QUEUE_DEPTH = 4;

   // Configuration port
   localparam int CSR_INDEX_WIDTH = 4;
   localparam int CSR_DATA_WIDTH  = 16;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_QUERY_ACTIVE = 4'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_EXPECTED_ID  = 4'd1;

   // Message layout
   localparam logic [3:0]  HEADER_LEN     = 4'd12;
   localparam logic [3:0]  FIXED_LAST     = 4'd9;   // last byte of type..rdlength
   localparam logic [15:0] QTAIL_LEN      = 16'd4;  // qtype + qclass
   localparam logic [15:0] TYPE_A         = 16'd1;
   localparam logic [15:0] A_RDATA_LEN    = 16'd4;

   typedef enum logic [2:0] {
      PH_HEADER = 3'd0,
      PH_LABEL  = 3'd1,
      PH_BODY   = 3'd2,
      PH_PTR    = 3'd3,
      PH_QTAIL  = 3'd4,
      PH_FIXED  = 3'd5,
      PH_RDATA  = 3'd6,
      PH_DONE   = 3'd7
   } phase_type;

   typedef enum logic [2:0] {
      ST_FOUND = 3'd0,
      ST_IDLE  = 3'd1,
      ST_SHORT = 3'd2,
      ST_BADID = 3'd3,
      ST_NONE  = 3'd4
   } status_type;

   // One queued byte with its classification
   typedef struct packed {
      logic [7:0] data;
      logic       last;
      logic       is_zero;  // end of name
      logic       is_ptr;   // compression pointer lead byte
   } entry_type;

endpackage

// File: hdl/daex_front.sv
// Front part: accepts message bytes, classifies them, queues them.
// Depends on daex_pkg.
module daex_front #(
   parameter int Depth = daex_pkg::QUEUE_DEPTH
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_data_byte,
   input  logic                req_last_byte,
   output logic                q_valid,
   output daex_pkg::entry_type q_entry,
   input  logic                q_pop
);

   localparam int PTR_W   = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int COUNT_W = $clog2(Depth + 1);

   daex_pkg::entry_type mem_ff [Depth];
   daex_pkg::entry_type new_entry;
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                push;

   assign req_stall = (count_ff == COUNT_W'(Depth));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_entry   = mem_ff[rd_ptr_ff];

   always_comb begin
      new_entry.data    = req_data_byte;
      new_entry.last    = req_last_byte;
      new_entry.is_zero = (req_data_byte == 8'h00);
      new_entry.is_ptr  = (req_data_byte[7:6] == 2'b11);
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= new_entry;
      end
   end

endmodule

// File: hdl/daex_back.sv
// Back part: walks the DNS message byte by byte and registers the result.
// Depends on daex_pkg.
module daex_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                q_valid,
   input  daex_pkg::entry_type q_entry,
   output logic                q_pop,
   input  logic                query_active,
   input  logic [15:0]         expected_id,
   output logic                found_clear,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [2:0]          rsp_status,
   output logic [31:0]         rsp_address
);

   daex_pkg::phase_type  phase_ff, phase_in;
   daex_pkg::status_type verdict_ff, verdict_in, status;
   logic [3:0]  pos_ff, pos_in;
   logic [15:0] hdr_ff, hdr_in;
   logic [15:0] qleft_ff, qleft_in;
   logic [15:0] aleft_ff, aleft_in;
   logic [15:0] skip_ff, skip_in;
   logic [3:0]  fidx_ff, fidx_in;
   logic [15:0] rtype_ff, rtype_in;
   logic [15:0] rlen_ff, rlen_in;
   logic [31:0] addr_ff, addr_in;
   logic [15:0] skip_dec;
   logic [7:0]  b;
   logic        is_a;
   logic        last_pop;

   logic                 rsp_valid_ff, rsp_valid_in;
   daex_pkg::status_type rsp_status_ff;
   logic [31:0]          rsp_address_ff;

   assign b        = q_entry.data;
   assign skip_dec = skip_ff - 16'd1;
   assign is_a     = (rtype_ff == daex_pkg::TYPE_A) && (rlen_ff == daex_pkg::A_RDATA_LEN);

   // A result can only be loaded when the output register frees up
   assign q_pop    = q_valid && (!q_entry.last || !rsp_valid_ff || !rsp_stall);
   assign last_pop = q_pop && q_entry.last;

   always_comb begin
      phase_in   = phase_ff;
      verdict_in = verdict_ff;
      hdr_in     = hdr_ff;
      qleft_in   = qleft_ff;
      aleft_in   = aleft_ff;
      skip_in    = skip_ff;
      fidx_in    = fidx_ff;
      rtype_in   = rtype_ff;
      rlen_in    = rlen_ff;
      addr_in    = addr_ff;
      pos_in     = (pos_ff == daex_pkg::HEADER_LEN) ? pos_ff : pos_ff + 4'd1;
      unique case (phase_ff)
         daex_pkg::PH_HEADER: begin
            unique case (pos_ff)
               4'd0:    hdr_in   = {b, 8'h00};
               4'd1:    hdr_in   = {hdr_ff[15:8], b};
               4'd4:    qleft_in = {b, 8'h00};
               4'd5:    qleft_in = {qleft_ff[15:8], b};
               4'd6:    aleft_in = {b, 8'h00};
               4'd7:    aleft_in = {aleft_ff[15:8], b};
               4'd11:   phase_in = (qleft_ff != '0 || aleft_ff != '0) ?
                                   daex_pkg::PH_LABEL : daex_pkg::PH_DONE;
               default: ;
            endcase
         end
         daex_pkg::PH_LABEL, daex_pkg::PH_PTR: begin
            if (phase_ff == daex_pkg::PH_LABEL && !q_entry.is_zero) begin
               if (q_entry.is_ptr) begin
                  phase_in = daex_pkg::PH_PTR;
               end else begin
                  skip_in  = {8'h00, b};
                  phase_in = daex_pkg::PH_BODY;
               end
            end else if (qleft_ff != '0) begin
               // name ended inside a question
               phase_in = daex_pkg::PH_QTAIL;
               skip_in  = daex_pkg::QTAIL_LEN;
            end else begin
               phase_in = daex_pkg::PH_FIXED;
               fidx_in  = '0;
            end
         end
         daex_pkg::PH_BODY: begin
            skip_in = skip_dec;
            if (skip_dec == '0) begin
               phase_in = daex_pkg::PH_LABEL;
            end
         end
         daex_pkg::PH_QTAIL: begin
            skip_in = skip_dec;
            if (skip_dec == '0) begin
               qleft_in = qleft_ff - 16'd1;
               phase_in = (qleft_in != '0 || aleft_ff != '0) ?
                          daex_pkg::PH_LABEL : daex_pkg::PH_DONE;
            end
         end
         daex_pkg::PH_FIXED: begin
            if (fidx_ff == 4'd0) rtype_in = {b, 8'h00};
            if (fidx_ff == 4'd1) rtype_in = {rtype_ff[15:8], b};
            if (fidx_ff == 4'd8) rlen_in  = {b, 8'h00};
            if (fidx_ff == 4'd9) rlen_in  = {rlen_ff[15:8], b};
            if (fidx_ff >= daex_pkg::FIXED_LAST) begin
               fidx_in = '0;
               addr_in = '0;
               if (rlen_in == '0) begin
                  aleft_in = aleft_ff - 16'd1;
                  phase_in = (qleft_ff != '0 || aleft_in != '0) ?
                             daex_pkg::PH_LABEL : daex_pkg::PH_DONE;
               end else begin
                  skip_in  = rlen_in;
                  phase_in = daex_pkg::PH_RDATA;
               end
            end else begin
               fidx_in = fidx_ff + 4'd1;
            end
         end
         daex_pkg::PH_RDATA: begin
            if (is_a) begin
               addr_in = {addr_ff[23:0], b};
            end
            skip_in = skip_dec;
            if (skip_dec == '0) begin
               if (is_a) begin
                  verdict_in = daex_pkg::ST_FOUND;
                  phase_in   = daex_pkg::PH_DONE;
               end else begin
                  aleft_in = aleft_ff - 16'd1;
                  phase_in = (qleft_ff != '0 || aleft_in != '0) ?
                             daex_pkg::PH_LABEL : daex_pkg::PH_DONE;
               end
            end
         end
         daex_pkg::PH_DONE: ;
         default: ;
      endcase
   end

   // Checks in order: idle, short, id, then parse verdict
   always_comb begin
      priority if (!query_active) begin
         status = daex_pkg::ST_IDLE;
      end else if (pos_in != daex_pkg::HEADER_LEN) begin
         status = daex_pkg::ST_SHORT;
      end else if (hdr_in != expected_id) begin
         status = daex_pkg::ST_BADID;
      end else begin
         status = verdict_in;
      end
   end

   assign found_clear = last_pop && (status == daex_pkg::ST_FOUND);

   always_ff @(posedge clock) begin
      if (reset || last_pop) begin
         phase_ff   <= daex_pkg::PH_HEADER;
         verdict_ff <= daex_pkg::ST_NONE;
         pos_ff     <= '0;
         hdr_ff     <= '0;
         qleft_ff   <= '0;
         aleft_ff   <= '0;
         skip_ff    <= '0;
         fidx_ff    <= '0;
         rtype_ff   <= '0;
         rlen_ff    <= '0;
         addr_ff    <= '0;
      end else if (q_pop) begin
         phase_ff   <= phase_in;
         verdict_ff <= verdict_in;
         pos_ff     <= pos_in;
         hdr_ff     <= hdr_in;
         qleft_ff   <= qleft_in;
         aleft_ff   <= aleft_in;
         skip_ff    <= skip_in;
         fidx_ff    <= fidx_in;
         rtype_ff   <= rtype_in;
         rlen_ff    <= rlen_in;
         addr_ff    <= addr_in;
      end
   end

   // Output register
   always_comb begin
      if (last_pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (last_pop) begin
         rsp_status_ff  <= status;
         rsp_address_ff <= (status == daex_pkg::ST_FOUND) ? addr_in : '0;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_status  = rsp_status_ff;
   assign rsp_address = rsp_address_ff;

endmodule

// File: hdl/dns_answer_address_extractor_core.sv
// Top level of the DNS answer address extractor: config registers plus
// front (classify + byte queue) and back (parser + output register).
// Depends on daex_pkg, daex_front, daex_back.
//
// Usage:
//  - req_*: one response byte per item (req_data_byte, req_last_byte marks
//    the final byte). Taken when req_valid is high and req_stall is low.
//  - rsp_*: exactly one item per message, produced for its final byte:
//    rsp_status (0 found, 1 no query, 2 short, 3 id mismatch, 4 no A record)
//    and rsp_address (zero unless found). Taken when rsp_valid && !rsp_stall.
//  - csr_*: index 0 query_active, index 1 expected_id; csr_ready is always
//    high. Write only while no message is in flight. A found result clears
//    query_active.
// Throughput: one byte per cycle, sustained, as long as results are taken.
// Result: the final byte, once taken, is written into the queue; when it is
//  popped from the queue its result is registered and rsp_valid rises.
// Stall: while rsp_stall holds a result, the back part keeps consuming
//  non-final bytes; the queue (QueueDepth bytes) then fills on the next
//  final byte and req_stall rises once it is full.
// Reset: clears queue, parser state, output valid and both registers.
module dns_answer_address_extractor_core #(
   parameter int QueueDepth = daex_pkg::QUEUE_DEPTH
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [7:0]                           req_data_byte,
   input  logic                                 req_last_byte,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [2:0]                           rsp_status,
   output logic [31:0]                          rsp_address,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [daex_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [daex_pkg::CSR_DATA_WIDTH-1:0]  csr_wdata
);

   logic                query_active_ff, query_active_in;
   logic [15:0]         expected_id_ff, expected_id_in;
   logic                q_valid;
   logic                q_pop;
   logic                found_clear;
   logic                csr_write;
   daex_pkg::entry_type q_entry;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   // Unknown indexes are dropped
   always_comb begin
      query_active_in = query_active_ff;
      expected_id_in  = expected_id_ff;
      if (found_clear) begin
         query_active_in = 1'b0;
      end
      if (csr_write && csr_index == daex_pkg::CSR_QUERY_ACTIVE) begin
         query_active_in = csr_wdata[0];
      end
      if (csr_write && csr_index == daex_pkg::CSR_EXPECTED_ID) begin
         expected_id_in = csr_wdata[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         query_active_ff <= 1'b0;
         expected_id_ff  <= '0;
      end else begin
         query_active_ff <= query_active_in;
         expected_id_ff  <= expected_id_in;
      end
   end

   daex_front #(
      .Depth (QueueDepth)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .q_valid       (q_valid),
      .q_entry       (q_entry),
      .q_pop         (q_pop)
   );

   daex_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_entry      (q_entry),
      .q_pop        (q_pop),
      .query_active (query_active_ff),
      .expected_id  (expected_id_ff),
      .found_clear  (found_clear),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_status   (rsp_status),
      .rsp_address  (rsp_address)
   );

endmodule

// File: hdl/daex_checker.sv
// Port-level checks for dns_answer_address_extractor_core, with bind.
// Depends on daex_pkg.
module daex_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_status,
   input logic [31:0] rsp_address
);

   a_rsp_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_req_open_after_reset: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("byte input stalled right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) && $stable(rsp_address))
      else $error("stalled result changed");

   a_addr_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != 3'(daex_pkg::ST_FOUND) |-> rsp_address == '0)
      else $error("address nonzero without a found status");

endmodule

bind dns_answer_address_extractor_core daex_checker u_daex_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_status  (rsp_status),
   .rsp_address (rsp_address)
);

// File: bench/dns_answer_address_extractor_core_tb.sv
// Testbench for dns_answer_address_extractor_core: directed and random DNS responses,
// checked item by item against a behavioral tracker of the parser.
// Depends on daex_pkg and the RTL under hdl/.
module dns_answer_address_extractor_core_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import daex_pkg::*;

   // ------------------------------------------------------------------
   // Run limits and local constants
   // ------------------------------------------------------------------
   localparam int CYCLE_LIMIT = 1000000;  // slowest legal run is far below this
   localparam int DRAIN_LIMIT = 5000;     // wait for outstanding results
   localparam int SETTLE      = 6;        // extra wait after the last answer
   localparam int HOLDOFF     = 300;      // long receiver hold-off, in cycles

   // unused register indexes: writes must be dropped
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_LO = 4'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNUSED_HI = 4'd15;

   // header byte offsets
   localparam logic [15:0] HDR_ID_HI = 16'd0;
   localparam logic [15:0] HDR_ID_LO = 16'd1;
   localparam logic [15:0] HDR_QD_HI = 16'd4;
   localparam logic [15:0] HDR_QD_LO = 16'd5;
   localparam logic [15:0] HDR_AN_HI = 16'd6;
   localparam logic [15:0] HDR_AN_LO = 16'd7;
   localparam logic [15:0] HDR_END   = 16'(HEADER_LEN) - 16'd1;

   // offsets inside the 10 fixed record bytes
   localparam logic [3:0] FIX_TYPE_HI = 4'd0;
   localparam logic [3:0] FIX_TYPE_LO = 4'd1;
   localparam logic [3:0] FIX_LEN_HI  = 4'd8;

   localparam logic [7:0]  PTR_MASK   = 8'hC0;
   localparam logic [15:0] TYPE_CNAME = 16'd5;
   localparam logic [15:0] TYPE_TXT   = 16'd16;
   localparam logic [15:0] TYPE_AAAA  = 16'd28;

   typedef struct packed {
      status_type  status;
      logic [31:0] address;
   } answer_type;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_RANDOM,
      STALL_TOGGLE,
      STALL_RUNS
   } stall_pattern_type;

   // ------------------------------------------------------------------
   // DUT signals; every input known from time zero
   // ------------------------------------------------------------------
   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic        req_last_byte = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_address;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata = '0;

   dns_answer_address_extractor_core u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_data_byte (req_data_byte),
      .req_last_byte (req_last_byte),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_status    (rsp_status),
      .rsp_address   (rsp_address),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   always #10 clock = ~clock;

   // ------------------------------------------------------------------
   // Bookkeeping
   // ------------------------------------------------------------------
   answer_type  expected_answers[$];  // one entry per final byte taken
   logic [7:0]  msg_bytes[$];         // message under construction
   int          fails = 0;
   int          cycles = 0;
   int          bytes_sent = 0;
   int          messages_sent = 0;
   int          results_seen = 0;
   int          input_held = 0;
   int          status_seen[0:7];

   // sender burst shaping
   int          burst_left = 0;
   bit          no_gaps = 1'b0;

   // receiver pattern; hold_left is loaded by a test at a falling edge
   int                hold_left = 0;
   int                pattern_left = 0;
   int                run_left = 0;
   bit                run_stall = 1'b0;
   stall_pattern_type stall_pattern = STALL_NONE;

   // ------------------------------------------------------------------
   // Behavioral tracker: mirrors the parse of the current message and the
   // two registers. Updated on every accepted byte / register write.
   // ------------------------------------------------------------------
   phase_type   trk_phase;
   status_type  trk_verdict;
   logic [15:0] trk_pos, trk_id, trk_qleft, trk_aleft, trk_skip, trk_rtype, trk_rlen;
   logic [3:0]  trk_field;
   logic [31:0] trk_addr;
   logic        reg_active;
   logic [15:0] reg_id;

   function automatic void clear_tracker();
      trk_pos     = '0;
      trk_phase   = PH_HEADER;
      trk_id      = '0;
      trk_qleft   = '0;
      trk_aleft   = '0;
      trk_skip    = '0;
      trk_field   = '0;
      trk_rtype   = '0;
      trk_rlen    = '0;
      trk_addr    = '0;
      trk_verdict = ST_NONE;
   endfunction

   // next name, or parse over when no question/answer remains
   function automatic void start_entry();
      trk_phase = (trk_qleft != 0 || trk_aleft != 0) ? PH_LABEL : PH_DONE;
   endfunction

   function automatic void end_name();
      if (trk_qleft != 0) begin
         trk_phase = PH_QTAIL;
         trk_skip  = QTAIL_LEN;
      end else begin
         trk_phase = PH_FIXED;
         trk_field = '0;
      end
   endfunction

   function automatic void end_record();
      trk_aleft = trk_aleft - 16'd1;
      start_entry();
   endfunction

   function automatic void track_byte(input logic [7:0] b);
      logic is_a;
      is_a = (trk_rtype == TYPE_A) && (trk_rlen == A_RDATA_LEN);
      case (trk_phase)
         PH_HEADER: begin
            case (trk_pos)
               HDR_ID_HI: trk_id    = {b, 8'h00};
               HDR_ID_LO: trk_id    = trk_id | {8'h00, b};
               HDR_QD_HI: trk_qleft = {b, 8'h00};
               HDR_QD_LO: trk_qleft = trk_qleft | {8'h00, b};
               HDR_AN_HI: trk_aleft = {b, 8'h00};
               HDR_AN_LO: trk_aleft = trk_aleft | {8'h00, b};
               HDR_END:   start_entry();
               default: ;
            endcase
         end
         PH_LABEL: begin
            if (b == 8'h00) begin
               end_name();
            end else if ((b & PTR_MASK) == PTR_MASK) begin
               trk_phase = PH_PTR;
            end else begin
               // 0x40..0xBF count as plain lengths too
               trk_skip  = {8'h00, b};
               trk_phase = PH_BODY;
            end
         end
         PH_BODY: begin
            trk_skip = trk_skip - 16'd1;
            if (trk_skip == 0) trk_phase = PH_LABEL;
         end
         PH_PTR: end_name();
         PH_QTAIL: begin
            trk_skip = trk_skip - 16'd1;
            if (trk_skip == 0) begin
               trk_qleft = trk_qleft - 16'd1;
               start_entry();
            end
         end
         PH_FIXED: begin
            if (trk_field == FIX_TYPE_HI)      trk_rtype = {b, 8'h00};
            else if (trk_field == FIX_TYPE_LO) trk_rtype = trk_rtype | {8'h00, b};
            else if (trk_field == FIX_LEN_HI)  trk_rlen  = {b, 8'h00};
            else if (trk_field == FIXED_LAST)  trk_rlen  = trk_rlen | {8'h00, b};
            if (trk_field >= FIXED_LAST) begin
               trk_field = '0;
               trk_addr  = '0;
               if (trk_rlen == 0) begin
                  end_record();
               end else begin
                  trk_skip  = trk_rlen;
                  trk_phase = PH_RDATA;
               end
            end else begin
               trk_field = trk_field + 4'd1;
            end
         end
         PH_RDATA: begin
            if (is_a) trk_addr = {trk_addr[23:0], b};
            trk_skip = trk_skip - 16'd1;
            if (trk_skip == 0) begin
               if (is_a) begin
                  trk_verdict = ST_FOUND;
                  trk_phase   = PH_DONE;
               end else begin
                  end_record();
               end
            end
         end
         default: ;
      endcase
   endfunction

   // one accepted byte; on the final byte queue the expected answer
   function automatic void predict_byte(input logic [7:0] b, input logic last);
      answer_type ans;
      track_byte(b);
      if (trk_pos != 16'hFFFF) trk_pos = trk_pos + 16'd1;  // saturates
      if (last) begin
         if (!reg_active)                      ans.status = ST_IDLE;
         else if (trk_pos < 16'(HEADER_LEN))   ans.status = ST_SHORT;
         else if (trk_id != reg_id)            ans.status = ST_BADID;
         else                                  ans.status = trk_verdict;
         ans.address = (ans.status == ST_FOUND) ? trk_addr : 32'h0;
         if (ans.status == ST_FOUND) reg_active = 1'b0;  // found disarms the query
         expected_answers.push_back(ans);
         clear_tracker();
      end
   endfunction

   function automatic void apply_register(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                          input logic [CSR_DATA_WIDTH-1:0] data);
      if (idx == CSR_QUERY_ACTIVE)     reg_active = data[0];
      else if (idx == CSR_EXPECTED_ID) reg_id     = data;
   endfunction

   // ------------------------------------------------------------------
   // Message construction
   // ------------------------------------------------------------------
   function automatic void put16(input logic [15:0] v);
      msg_bytes.push_back(v[15:8]);
      msg_bytes.push_back(v[7:0]);
   endfunction

   // flags, NS and AR counts are random: the block ignores them
   function automatic void put_header(input logic [15:0] id, input logic [15:0] qd,
                                      input logic [15:0] an);
      put16(id);
      put16(16'($urandom));
      put16(qd);
      put16(an);
      put16(16'($urandom));
      put16(16'($urandom));
   endfunction

   function automatic void put_label(input int unsigned len);
      msg_bytes.push_back(8'(len));
      repeat (len) msg_bytes.push_back(8'($urandom));
   endfunction

   // labels, then either a root zero or a two-byte pointer
   function automatic void put_name(input int labels, input bit compressed);
      int unsigned len;
      for (int i = 0; i < labels; i++) begin
         len = ($urandom_range(0, 24) == 0) ? $urandom_range(8'h40, 8'hBF)
                                            : $urandom_range(1, 8);
         put_label(len);
      end
      if (compressed) begin
         msg_bytes.push_back({2'b11, 6'($urandom)});
         msg_bytes.push_back(8'($urandom));
      end else begin
         msg_bytes.push_back(8'h00);
      end
   endfunction

   function automatic void put_question(input int labels, input bit compressed);
      put_name(labels, compressed);
      put16(16'($urandom));
      put16(16'($urandom));
   endfunction

   function automatic void put_record(input logic [15:0] rtype, input logic [15:0] rdlen,
                                      input int labels, input bit compressed);
      put_name(labels, compressed);
      put16(rtype);
      put16(16'($urandom));  // class, ignored
      put16(16'($urandom));
      put16(16'($urandom));
      put16(rdlen);
      repeat (rdlen) msg_bytes.push_back(8'($urandom));
   endfunction

   function automatic void put_a_record(input logic [31:0] addr, input int labels,
                                        input bit compressed);
      put_name(labels, compressed);
      put16(TYPE_A);
      put16(16'($urandom));
      put16(16'($urandom));
      put16(16'($urandom));
      put16(A_RDATA_LEN);
      put16(addr[31:16]);
      put16(addr[15:0]);
   endfunction

   function automatic void put_junk(input int n);
      repeat (n) msg_bytes.push_back(8'($urandom));
   endfunction

   function automatic void cut_to(input int n);
      while (msg_bytes.size() > n) void'(msg_bytes.pop_back());
   endfunction

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------
   // Sends one byte; the sender works in random bursts with idle gaps unless no_gaps is set.
   task automatic send_byte(input logic [7:0] b, input logic last);
      if (!no_gaps && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
         burst_left = $urandom_range(1, 16);
      end
      req_valid     <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= last;
      do @(posedge clock); while (req_stall);
      predict_byte(b, last);
      if (burst_left != 0) burst_left--;
      bytes_sent++;
   endtask

   task automatic send_message();
      for (int i = 0; i < msg_bytes.size(); i++)
         send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
      msg_bytes.delete();
      messages_sent++;
   endtask

   // csr_valid stays high across back-to-back writes; end_writes lowers it
   task automatic write_register(input logic [CSR_INDEX_WIDTH-1:0] idx,
                                 input logic [CSR_DATA_WIDTH-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      apply_register(idx, data);
   endtask

   task automatic end_writes();
      csr_valid <= 1'b0;
   endtask

   // Stop sending, wait for every outstanding answer, then let the
   // pipeline settle. Leftovers after the limit are failures.
   task automatic drain();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      while (expected_answers.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      if (expected_answers.size() != 0) begin
         $error("%0d expected answers never arrived", expected_answers.size());
         fails++;
         expected_answers.delete();
      end
      repeat (SETTLE) @(posedge clock);
   endtask

   // Registers change only while the block is idle.
   task automatic load_registers(input logic [15:0] active_word, input logic [15:0] id);
      drain();
      write_register(CSR_QUERY_ACTIVE, active_word);
      write_register(CSR_EXPECTED_ID, id);
      end_writes();
   endtask

   // ------------------------------------------------------------------
   // Receiver: stalls on a changing pattern, or holds off for hold_left cycles
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_left != 0) begin
         hold_left = hold_left - 1;
         rsp_stall <= 1'b1;
      end else begin
         if (pattern_left == 0) begin
            stall_pattern = stall_pattern_type'($urandom_range(0, 3));
            pattern_left  = $urandom_range(50, 250);
         end else begin
            pattern_left--;
         end
         case (stall_pattern)
            STALL_NONE:   rsp_stall <= 1'b0;
            STALL_RANDOM: rsp_stall <= ($urandom_range(0, 2) == 0);
            STALL_TOGGLE: rsp_stall <= ~rsp_stall;
            default: begin
               if (run_left == 0) begin
                  run_stall = ~run_stall;
                  run_left  = $urandom_range(1, 20);
               end else begin
                  run_left--;
               end
               rsp_stall <= run_stall;
            end
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Result checker: each taken item against the oldest expectation
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      answer_type exp_ans;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         status_seen[rsp_status]++;
         if (expected_answers.size() == 0) begin
            $error("unexpected result: status %0d address %h", rsp_status, rsp_address);
            fails++;
         end else begin
            exp_ans = expected_answers.pop_front();
            if (rsp_status !== exp_ans.status) begin
               $error("status: expected %0d, actual %0d", exp_ans.status, rsp_status);
               fails++;
            end
            if (rsp_address !== exp_ans.address) begin
               $error("address: expected %h, actual %h", exp_ans.address, rsp_address);
               fails++;
            end
         end
      end
   end

   // cycle budget and input back-pressure count
   always @(posedge clock) begin
      cycles++;
      if (req_valid && req_stall) input_held++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // No query armed, then the short check ahead of the id check.
   task automatic test_status_precedence();
      // registers at reset: id 0 matches, but nothing is armed
      put_header(16'h0000, 16'd1, 16'd1);
      put_question(2, 1'b0);
      put_a_record(32'h0A00_0001, 0, 1'b1);
      send_message();
      msg_bytes.push_back(8'hFF);  // one byte, idle beats short
      send_message();

      load_registers(16'h0001, 16'h1234);
      msg_bytes.push_back(8'h00);
      send_message();
      put_header(16'hABCD, 16'd0, 16'd0);  // 11 bytes, wrong id: short wins
      cut_to(11);
      send_message();
      put_header(16'hABCD, 16'd0, 16'd0);  // full header, wrong id
      send_message();
      put_header(16'h1234, 16'd0, 16'd0);  // matches, no answers
      send_message();
   endtask

   // Header-only messages at the byte extremes.
   task automatic test_header_extremes();
      load_registers(16'h0001, 16'hFFFF);
      repeat (12) msg_bytes.push_back(8'hFF);  // huge counts, cut after header
      send_message();
      load_registers(16'h0001, 16'h0000);
      repeat (12) msg_bytes.push_back(8'h00);
      send_message();
   endtask

   // Address found; found clears the query so the repeat is ignored.
   task automatic test_address_found();
      logic [15:0] id;
      id = 16'($urandom);
      load_registers(16'h0001, id);
      put_header(id, 16'd1, 16'd1);
      put_question(3, 1'b0);
      put_a_record(32'hFFFF_FFFF, 0, 1'b1);
      send_message();
      put_header(id, 16'd0, 16'd1);
      put_a_record(32'h1122_3344, 1, 1'b0);
      send_message();
      load_registers(16'h0001, id);
      put_header(id, 16'd0, 16'd1);
      put_a_record(32'h0000_0000, 2, 1'b0);
      send_message();
   endtask

   // Records that are not a usable A record are stepped over.
   task automatic test_record_skipping();
      load_registers(16'h0001, 16'h5A5A);
      put_header(16'h5A5A, 16'd2, 16'd6);
      put_question(1, 1'b1);
      put_question(0, 1'b1);
      put_record(TYPE_CNAME, 16'd7, 1, 1'b1);
      put_record(TYPE_A, 16'd16, 0, 1'b1);     // type A, wrong length
      put_record(TYPE_AAAA, 16'd4, 0, 1'b1);   // length 4, wrong type
      put_record(TYPE_A, 16'd0, 0, 1'b0);      // empty rdata
      put_record(16'hFFFF, 16'd3, 0, 1'b1);
      put_a_record(32'hC0A8_0101, 0, 1'b1);
      send_message();
      load_registers(16'h0001, 16'h5A5A);
      put_header(16'h5A5A, 16'd0, 16'd2);     // no usable A record
      put_record(TYPE_CNAME, 16'd5, 2, 1'b0);
      put_record(TYPE_A, 16'd2, 0, 1'b1);
      send_message();
   endtask

   // Label length bytes 0x40..0xBF are plain lengths.
   task automatic test_long_labels();
      load_registers(16'h0001, 16'h0F0F);
      put_header(16'h0F0F, 16'd1, 16'd1);
      put_label(8'h40);
      put_label(8'hBF);
      msg_bytes.push_back(8'h00);
      put16(16'($urandom));
      put16(16'($urandom));
      put_label(8'h7F);
      msg_bytes.push_back(8'hC0);
      msg_bytes.push_back(8'h0C);
      put16(TYPE_A);
      put16(16'hFFFF);
      put16(16'($urandom));
      put16(16'($urandom));
      put16(A_RDATA_LEN);
      put16(16'h8000);
      put16(16'h0001);
      send_message();
   endtask

   // Bytes after the parse is over do not disturb the answer.
   task automatic test_trailing_bytes();
      load_registers(16'h0001, 16'h7777);
      put_header(16'h7777, 16'd0, 16'd2);
      put_a_record(32'h0102_0304, 0, 1'b1);
      put_a_record(32'hAABB_CCDD, 0, 1'b1);   // second A record is ignored
      put_junk(9);
      send_message();
      load_registers(16'h0001, 16'h7777);
      put_header(16'h7777, 16'd0, 16'd0);
      put_junk(10);
      send_message();
   endtask

   // The final byte arrives in the middle of a record or a question.
   task automatic test_truncated();
      load_registers(16'h0001, 16'h3C3C);
      put_header(16'h3C3C, 16'd0, 16'd1);
      put_a_record(32'h0909_0909, 0, 1'b1);
      cut_to(msg_bytes.size() - 2);           // inside the address
      send_message();
      put_header(16'h3C3C, 16'd0, 16'd1);
      put_a_record(32'h0909_0909, 0, 1'b1);
      cut_to(18);                             // inside the fixed part
      send_message();
      put_header(16'h3C3C, 16'd1, 16'd1);
      put_question(2, 1'b0);
      cut_to(15);                             // inside a label
      send_message();
   endtask

   // Writes to unused indexes change nothing; only bit 0 arms the query.
   task automatic test_unused_register();
      load_registers(16'hFFFE, 16'h4242);     // bit 0 clear: not armed
      put_header(16'h4242, 16'd0, 16'd1);
      put_a_record(32'h0505_0505, 0, 1'b1);
      send_message();
      load_registers(16'hFFFF, 16'h4242);
      write_register(CSR_UNUSED_LO, 16'h0000);
      write_register(CSR_UNUSED_HI, 16'hFFFF);
      end_writes();
      put_header(16'h4242, 16'd0, 16'd1);
      put_a_record(32'h5050_5050, 0, 1'b1);
      send_message();
   endtask

   // A long record: the position runs far past the header, the parse goes on.
   task automatic test_long_message();
      load_registers(16'h0001, 16'h6161);
      no_gaps = 1'b1;
      put_header(16'h6161, 16'd0, 16'd2);
      put_record(TYPE_TXT, 16'd100, 0, 1'b1);
      put_a_record(32'($urandom), 0, 1'b1);
      send_message();
      no_gaps = 1'b0;
   endtask

   // The receiver holds off for a long stretch while bytes keep coming,
   // so the byte queue fills and req_stall rises.
   task automatic test_receiver_holdoff();
      load_registers(16'h0001, 16'h2468);
      no_gaps = 1'b1;
      @(negedge clock);
      hold_left = HOLDOFF;
      @(posedge clock);
      repeat (8) begin
         put_header(16'h2468, 16'd0, 16'd1);
         put_a_record(32'($urandom), 0, 1'b1);
         send_message();
      end
      no_gaps = 1'b0;
   endtask

   function automatic void random_record();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: put_a_record(32'($urandom), $urandom_range(0, 2), $urandom_range(0, 1));
         4: put_record(TYPE_CNAME, 16'($urandom_range(1, 12)), $urandom_range(0, 2), 1'b1);
         5: put_record(TYPE_A, 16'($urandom_range(0, 6)), 0, $urandom_range(0, 1));
         6: put_record(TYPE_AAAA, 16'd16, 0, 1'b1);
         7: put_record(TYPE_AAAA, A_RDATA_LEN, 1, 1'b0);
         8: put_record(16'($urandom), 16'd0, 0, 1'b1);
         default: put_record(16'($urandom), 16'($urandom_range(0, 8)), $urandom_range(0, 2),
                             $urandom_range(0, 1));
      endcase
   endfunction

   // Mostly well-formed responses with random content; some carry a wrong
   // id or wrong counts, some are cut short, a few are pure noise.
   task automatic random_message();
      int unsigned kind, nq, na;
      logic [15:0] id, qd_field, an_field;
      kind = $urandom_range(0, 99);
      if (kind < 6) begin
         put_junk($urandom_range(1, 40));
      end else begin
         id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : reg_id;
         nq = $urandom_range(0, 2);
         na = $urandom_range(0, 3);
         qd_field = ($urandom_range(0, 15) == 0) ? 16'($urandom_range(0, 4)) : 16'(nq);
         an_field = ($urandom_range(0, 11) == 0) ? 16'($urandom) : 16'(na);
         put_header(id, qd_field, an_field);
         repeat (nq) put_question($urandom_range(0, 2), $urandom_range(0, 1));
         repeat (na) random_record();
         if ($urandom_range(0, 6) == 0) put_junk($urandom_range(1, 8));
         if (kind < 18) cut_to($urandom_range(1, msg_bytes.size()));
      end
      send_message();
   endtask

   task automatic test_random_messages();
      logic [15:0] id;
      while (bytes_sent < 1100 || messages_sent < 40) begin
         case ($urandom_range(0, 5))
            0:       id = 16'h0000;
            1:       id = 16'hFFFF;
            default: id = 16'($urandom);
         endcase
         load_registers({15'($urandom), 1'($urandom_range(0, 9) != 0)}, id);
         no_gaps = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(1, 3)) random_message();
      end
      no_gaps = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      foreach (status_seen[i]) status_seen[i] = 0;
      clear_tracker();
      reg_active = 1'b0;
      reg_id     = '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      test_status_precedence();
      test_header_extremes();
      test_address_found();
      test_record_skipping();
      test_long_labels();
      test_trailing_bytes();
      test_truncated();
      test_unused_register();
      test_long_message();
      test_receiver_holdoff();
      test_random_messages();
      drain();

      $display("covered %0d messages / %0d bytes, %0d answers; input back-pressured %0d cycles",
               messages_sent, bytes_sent, results_seen, input_held);
      $display("answers: found %0d, no query %0d, short %0d, id mismatch %0d, no A record %0d",
               status_seen[ST_FOUND], status_seen[ST_IDLE], status_seen[ST_SHORT],
               status_seen[ST_BADID], status_seen[ST_NONE]);
      if (fails == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: dns_answer_address_extractor_core.f
hdl/daex_pkg.sv
hdl/daex_front.sv
hdl/daex_back.sv
hdl/dns_answer_address_extractor_core.sv
hdl/daex_checker.sv
bench/dns_answer_address_extractor_core_tb.sv
